FILE: rtl/chip8_pkg.sv
// shared types and constants of the chip-8 execute unit
package chip8_pkg;

   localparam int MEM_DEPTH   = 4096;
   localparam int STACK_DEPTH = 16;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH);

   localparam logic [11:0] PC_RESET   = 12'h200;
   localparam logic [11:0] FONT_RESET = 12'h050;

   localparam logic [1:0] KIND_EXEC  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] opcode;
      logic [15:0] keys;
      logic [7:0]  random_byte;
      logic [11:0] mem_address;
      logic [7:0]  mem_data;
   } req_type;

   typedef struct packed {
      logic [11:0] next_pc;
      logic [15:0] index_value;
      logic        clear_screen;
      logic        waiting_key;
      logic        bad_opcode;
      logic [7:0]  read_data;
      logic [7:0]  sound_value;
   } rsp_type;

endpackage

FILE: rtl/chip8_ram.sv
// generic single write port ram with registered read
module chip8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

FILE: rtl/chip8_instruction_execute_unit.sv
// chip-8 execute unit top level: sequencer around register, stack and byte memories
//
// One item is taken when start is high and busy is low; busy stays high until the
// single result strobe (rsp_valid, one cycle, cannot be held off) has gone out.
// Steps from transfer to result strobe: memory write and kind 3 go straight to the
// result step, memory read adds a read step, most opcodes take three register-file
// reads for Vx, Vy and V0, one execute and one result step; flag-setting ALU ops and
// return add a step, Fx33 adds three digit writes, Fx55 and Fx65 a read and a write
// step per register V0..Vx. Register file and byte memory, each with a registered
// read, take every access in turn. After reset busy stays high while V0..VF are
// cleared one per cycle; memory and call stack power up undefined and are not
// cleared. The font base register may be written only while busy is low.
module chip8_instruction_execute_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  chip8_pkg::req_type  req_data,
   output logic                rsp_valid,
   output chip8_pkg::rsp_type  rsp_data,
   input  logic                csr_we,
   input  logic [11:0]         csr_wdata
);

   localparam int MAW = chip8_pkg::MEM_AW;
   localparam int SPW = chip8_pkg::SP_W;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RDX   = 4'd1;
   localparam logic [3:0] S_RDY   = 4'd2;
   localparam logic [3:0] S_RD0   = 4'd3;
   localparam logic [3:0] S_EXEC  = 4'd4;
   localparam logic [3:0] S_FLAG  = 4'd5;
   localparam logic [3:0] S_RET   = 4'd6;
   localparam logic [3:0] S_BCD   = 4'd7;
   localparam logic [3:0] S_STRD  = 4'd8;
   localparam logic [3:0] S_STWR  = 4'd9;
   localparam logic [3:0] S_LDRD  = 4'd10;
   localparam logic [3:0] S_LDWR  = 4'd11;
   localparam logic [3:0] S_MRD   = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;
   localparam logic [3:0] S_CLR   = 4'd14;

   logic [3:0]          state_ff, state_in;
   chip8_pkg::req_type  req_ff, req_in;
   logic [11:0]         pc_ff, pc_in;
   logic [15:0]         index_ff, index_in;
   logic [SPW-1:0]      sp_ff, sp_in;
   logic [7:0]          dt_ff, dt_in;
   logic [7:0]          st_ff, st_in;
   logic [11:0]         font_ff;
   logic [7:0]          vx_ff, vx_in, vy_ff, vy_in, v0_ff, v0_in;
   logic [7:0]          flag_ff, flag_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [2:0][3:0]     bcd_ff, bcd_in;
   logic                cls_ff, cls_in, wait_ff, wait_in, bad_ff, bad_in;
   logic [7:0]          rd_ff, rd_in;

   // memory ports
   logic                vr_we;
   logic [3:0]          vr_waddr, vr_raddr;
   logic [7:0]          vr_wdata, vr_rdata;
   logic                stk_we;
   logic [SPW-1:0]      stk_waddr, stk_raddr;
   logic [11:0]         stk_wdata, stk_rdata;
   logic                mem_we;
   logic [MAW-1:0]      mem_waddr, mem_raddr;
   logic [7:0]          mem_wdata, mem_rdata;

   // opcode fields of the held item
   logic [3:0]  op_hi, op_x, op_y, op_n;
   logic [7:0]  op_kk;
   logic [11:0] op_nnn;
   logic [11:0] pc2;
   logic [MAW-1:0] blk_addr;
   logic [8:0]  sum9;
   logic [3:0]  key_idx;
   logic        key_found;
   logic [7:0]  bcd_rem;
   logic [1:0]  bcd_h;
   logic [17:0] tens_prod;
   logic [3:0]  bcd_t;
   logic [7:0]  bcd_u;

   assign op_hi  = req_ff.opcode[15:12];
   assign op_x   = req_ff.opcode[11:8];
   assign op_y   = req_ff.opcode[7:4];
   assign op_n   = req_ff.opcode[3:0];
   assign op_kk  = req_ff.opcode[7:0];
   assign op_nnn = req_ff.opcode[11:0];
   assign pc2    = pc_ff + 12'd2;
   assign sum9   = {1'b0, vx_ff} + {1'b0, vy_ff};
   // block transfers walk index + step, wrapping at the memory size
   assign blk_addr = index_ff[MAW-1:0] + MAW'(cnt_ff);

   // lowest pressed key for key wait
   always_comb begin
      key_idx   = 4'd0;
      key_found = |req_ff.keys;
      for (int k = 15; k >= 0; k--) begin
         if (req_ff.keys[k]) begin
            key_idx = 4'(k);
         end
      end
   end

   // decimal digits of vx: hundreds by compare, tens by reciprocal multiply
   always_comb begin
      if (vx_ff >= 8'd200) begin
         bcd_h = 2'd2;
      end else if (vx_ff >= 8'd100) begin
         bcd_h = 2'd1;
      end else begin
         bcd_h = 2'd0;
      end
      bcd_rem   = vx_ff - 8'(bcd_h) * 8'd100;
      tens_prod = 18'(bcd_rem) * 18'd205;
      bcd_t     = tens_prod[14:11];
      bcd_u     = bcd_rem - 8'(bcd_t) * 8'd10;
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      pc_in    = pc_ff;
      index_in = index_ff;
      sp_in    = sp_ff;
      dt_in    = dt_ff;
      st_in    = st_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      v0_in    = v0_ff;
      flag_in  = flag_ff;
      cnt_in   = cnt_ff;
      bcd_in   = bcd_ff;
      cls_in   = cls_ff;
      wait_in  = wait_ff;
      bad_in   = bad_ff;
      rd_in    = rd_ff;

      vr_we     = 1'b0;
      vr_waddr  = op_x;
      vr_wdata  = 8'd0;
      vr_raddr  = 4'd0;
      stk_we    = 1'b0;
      stk_waddr = sp_ff;
      stk_wdata = pc2;
      stk_raddr = sp_ff - SPW'(1);
      mem_we    = 1'b0;
      mem_waddr = blk_addr;
      mem_wdata = 8'd0;
      mem_raddr = blk_addr;

      case (state_ff)
         S_CLR: begin
            // zero V0..VF one per cycle after reset
            vr_we    = 1'b1;
            vr_waddr = cnt_ff;
            vr_wdata = 8'd0;
            if (cnt_ff == 4'hF) begin
               cnt_in   = 4'd0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_IDLE: begin
            vr_raddr  = req_data.opcode[11:8];
            mem_raddr = MAW'(req_data.mem_address);
            mem_waddr = MAW'(req_data.mem_address);
            mem_wdata = req_data.mem_data;
            if (start) begin
               req_in  = req_data;
               cls_in  = 1'b0;
               wait_in = 1'b0;
               bad_in  = 1'b0;
               rd_in   = 8'd0;
               case (req_data.kind)
                  chip8_pkg::KIND_EXEC:  state_in = S_RDX;
                  chip8_pkg::KIND_WRITE: begin
                     mem_we   = 1'b1;
                     state_in = S_DONE;
                  end
                  chip8_pkg::KIND_READ:  state_in = S_MRD;
                  default:               state_in = S_DONE;
               endcase
            end
         end
         S_RDX: begin
            vx_in    = vr_rdata;
            vr_raddr = op_y;
            state_in = S_RDY;
         end
         S_RDY: begin
            vy_in    = vr_rdata;
            vr_raddr = 4'd0;
            state_in = S_RD0;
         end
         S_RD0: begin
            v0_in    = vr_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            pc_in    = pc2;
            state_in = S_DONE;
            case (op_hi)
               4'h0: begin
                  if (req_ff.opcode == 16'h00E0) begin
                     cls_in = 1'b1;
                  end else if (req_ff.opcode == 16'h00EE) begin
                     sp_in    = sp_ff - SPW'(1);
                     state_in = S_RET;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               4'h1: pc_in = op_nnn;
               4'h2: begin
                  stk_we = 1'b1;
                  sp_in  = sp_ff + SPW'(1);
                  pc_in  = op_nnn;
               end
               4'h3: if (vx_ff == op_kk) pc_in = pc2 + 12'd2;
               4'h4: if (vx_ff != op_kk) pc_in = pc2 + 12'd2;
               4'h5: begin
                  if (op_n != 4'd0) begin
                     bad_in = 1'b1;
                  end else if (vx_ff == vy_ff) begin
                     pc_in = pc2 + 12'd2;
                  end
               end
               4'h6: begin
                  vr_we    = 1'b1;
                  vr_wdata = op_kk;
               end
               4'h7: begin
                  vr_we    = 1'b1;
                  vr_wdata = vx_ff + op_kk;
               end
               4'h8: begin
                  vr_we = 1'b1;
                  case (op_n)
                     4'h0: vr_wdata = vy_ff;
                     4'h1: vr_wdata = vx_ff | vy_ff;
                     4'h2: vr_wdata = vx_ff & vy_ff;
                     4'h3: vr_wdata = vx_ff ^ vy_ff;
                     4'h4: begin
                        vr_wdata = sum9[7:0];
                        flag_in  = {7'd0, sum9[8]};
                        state_in = S_FLAG;
                     end
                     4'h5: begin
                        vr_wdata = vx_ff - vy_ff;
                        flag_in  = {7'd0, vx_ff > vy_ff};
                        state_in = S_FLAG;
                     end
                     4'h6: begin
                        vr_wdata = {1'b0, vx_ff[7:1]};
                        flag_in  = {7'd0, vx_ff[0]};
                        state_in = S_FLAG;
                     end
                     4'h7: begin
                        vr_wdata = vy_ff - vx_ff;
                        flag_in  = {7'd0, vy_ff > vx_ff};
                        state_in = S_FLAG;
                     end
                     4'hE: begin
                        vr_wdata = {vx_ff[6:0], 1'b0};
                        flag_in  = {7'd0, vx_ff[7]};
                        state_in = S_FLAG;
                     end
                     default: begin
                        vr_we  = 1'b0;
                        bad_in = 1'b1;
                     end
                  endcase
               end
               4'h9: begin
                  if (op_n != 4'd0) begin
                     bad_in = 1'b1;
                  end else if (vx_ff != vy_ff) begin
                     pc_in = pc2 + 12'd2;
                  end
               end
               4'hA: index_in = {4'd0, op_nnn};
               4'hB: pc_in = op_nnn + {4'd0, v0_ff};
               4'hC: begin
                  vr_we    = 1'b1;
                  vr_wdata = req_ff.random_byte & op_kk;
               end
               4'hE: begin
                  if (op_kk == 8'h9E) begin
                     if (req_ff.keys[vx_ff[3:0]]) pc_in = pc2 + 12'd2;
                  end else if (op_kk == 8'hA1) begin
                     if (!req_ff.keys[vx_ff[3:0]]) pc_in = pc2 + 12'd2;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               4'hF: begin
                  case (op_kk)
                     8'h07: begin
                        vr_we    = 1'b1;
                        vr_wdata = dt_ff;
                     end
                     8'h0A: begin
                        if (key_found) begin
                           vr_we    = 1'b1;
                           vr_wdata = {4'd0, key_idx};
                        end else begin
                           pc_in   = pc_ff;
                           wait_in = 1'b1;
                        end
                     end
                     8'h15: dt_in = vx_ff;
                     8'h18: st_in = vx_ff;
                     8'h1E: index_in = index_ff + {8'd0, vx_ff};
                     8'h29: index_in = {4'd0, font_ff}
                                       + {10'd0, vx_ff[3:0], 2'b00}
                                       + {12'd0, vx_ff[3:0]};
                     8'h33: begin
                        bcd_in   = {bcd_u[3:0], bcd_t, {2'd0, bcd_h}};
                        cnt_in   = 4'd0;
                        state_in = S_BCD;
                     end
                     8'h55: begin
                        cnt_in   = 4'd0;
                        state_in = S_STRD;
                     end
                     8'h65: begin
                        cnt_in   = 4'd0;
                        state_in = S_LDRD;
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
               default: bad_in = 1'b1;   // draw
            endcase
         end
         S_FLAG: begin
            // flag lands after vx so that VF as destination ends with the flag
            vr_we    = 1'b1;
            vr_waddr = 4'hF;
            vr_wdata = flag_ff;
            state_in = S_DONE;
         end
         S_RET: begin
            pc_in    = stk_rdata;
            state_in = S_DONE;
         end
         S_BCD: begin
            mem_we    = 1'b1;
            mem_wdata = {4'd0, bcd_ff[cnt_ff[1:0]]};
            if (cnt_ff == 4'd2) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_STRD: begin
            vr_raddr = cnt_ff;
            state_in = S_STWR;
         end
         S_STWR: begin
            mem_we    = 1'b1;
            mem_wdata = vr_rdata;
            if (cnt_ff == op_x) begin
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = S_STRD;
            end
         end
         S_LDRD: begin
            state_in = S_LDWR;
         end
         S_LDWR: begin
            vr_we    = 1'b1;
            vr_waddr = cnt_ff;
            vr_wdata = mem_rdata;
            if (cnt_ff == op_x) begin
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = S_LDRD;
            end
         end
         S_MRD: begin
            rd_in    = mem_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff   <= 4'd0;
         pc_ff    <= chip8_pkg::PC_RESET;
         index_ff <= 16'd0;
         sp_ff    <= '0;
         dt_ff    <= 8'd0;
         st_ff    <= 8'd0;
         font_ff  <= chip8_pkg::FONT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pc_ff    <= pc_in;
         index_ff <= index_in;
         sp_ff    <= sp_in;
         dt_ff    <= dt_in;
         st_ff    <= st_in;
         if (csr_we) begin
            font_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      v0_ff   <= v0_in;
      flag_ff <= flag_in;
      bcd_ff  <= bcd_in;
      cls_ff  <= cls_in;
      wait_ff <= wait_in;
      bad_ff  <= bad_in;
      rd_ff   <= rd_in;
   end

   // V0..VF
   chip8_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
      .clock (clock),
      .we    (vr_we),
      .waddr (vr_waddr),
      .wdata (vr_wdata),
      .raddr (vr_raddr),
      .rdata (vr_rdata)
   );

   // return addresses
   chip8_ram #(.WIDTH(12), .DEPTH(chip8_pkg::STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // program and data bytes
   chip8_ram #(.WIDTH(8), .DEPTH(chip8_pkg::MEM_DEPTH)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      rsp_data.next_pc      = pc_ff;
      rsp_data.index_value  = index_ff;
      rsp_data.clear_screen = cls_ff;
      rsp_data.waiting_key  = wait_ff;
      rsp_data.bad_opcode   = bad_ff;
      rsp_data.read_data    = rd_ff;
      rsp_data.sound_value  = st_ff;
   end

`ifndef SYNTHESIS
   // a transfer always leads to a busy block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   // one result per transfer, strobe never stays high for consecutive cycles
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the block is free again right after a result
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy after result transfer");
`endif

endmodule

FILE: test/tb_chip8_instruction_execute_unit.sv
// self-checking testbench of the chip-8 execute unit: directed and random items
module tb_chip8_instruction_execute_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   chip8_pkg::req_type  req_data;
   logic                rsp_valid;
   chip8_pkg::rsp_type  rsp_data;
   logic                csr_we;
   logic [11:0]         csr_wdata;

   chip8_instruction_execute_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the machine state
   logic [7:0]  shadow_v [16];
   logic [11:0] shadow_pc;
   logic [15:0] shadow_index;
   logic [11:0] shadow_stack [16];
   logic [3:0]  shadow_sp;
   logic [7:0]  shadow_delay;
   logic [7:0]  shadow_sound;
   logic [7:0]  shadow_mem [chip8_pkg::MEM_DEPTH];
   logic [11:0] shadow_font;
   // which memory bytes and stack slots hold known data
   bit          mem_known [chip8_pkg::MEM_DEPTH];
   int          stack_depth_known;

   chip8_pkg::rsp_type expected_rsps [$];
   int          error_count;
   int          idle_cycles;
   int          send_gap_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // predict one item and update the shadow state
   function automatic chip8_pkg::rsp_type predict_item(chip8_pkg::req_type it);
      chip8_pkg::rsp_type r;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, vx, vy;
      logic [11:0] nnn;
      logic [8:0]  wide;
      int          i;
      r = '0;
      x = it.opcode[11:8];
      y = it.opcode[7:4];
      n = it.opcode[3:0];
      kk = it.opcode[7:0];
      nnn = it.opcode[11:0];
      vx = shadow_v[x];
      vy = shadow_v[y];
      if (it.kind == chip8_pkg::KIND_WRITE) begin
         shadow_mem[it.mem_address] = it.mem_data;
      end else if (it.kind == chip8_pkg::KIND_READ) begin
         r.read_data = shadow_mem[it.mem_address];
      end else if (it.kind == chip8_pkg::KIND_EXEC) begin
         shadow_pc = shadow_pc + 12'd2;
         case (it.opcode[15:12])
            4'h0: begin
               if (it.opcode == 16'h00E0) r.clear_screen = 1'b1;
               else if (it.opcode == 16'h00EE) begin
                  shadow_sp = shadow_sp - 4'd1;
                  shadow_pc = shadow_stack[shadow_sp];
               end else r.bad_opcode = 1'b1;
            end
            4'h1: shadow_pc = nnn;
            4'h2: begin
               shadow_stack[shadow_sp] = shadow_pc;
               shadow_sp = shadow_sp + 4'd1;
               shadow_pc = nnn;
            end
            4'h3: if (vx == kk) shadow_pc = shadow_pc + 12'd2;
            4'h4: if (vx != kk) shadow_pc = shadow_pc + 12'd2;
            4'h5: begin
               if (n != 0) r.bad_opcode = 1'b1;
               else if (vx == vy) shadow_pc = shadow_pc + 12'd2;
            end
            4'h6: shadow_v[x] = kk;
            4'h7: shadow_v[x] = vx + kk;
            4'h8: begin
               case (n)
                  4'h0: shadow_v[x] = vy;
                  4'h1: shadow_v[x] = vx | vy;
                  4'h2: shadow_v[x] = vx & vy;
                  4'h3: shadow_v[x] = vx ^ vy;
                  4'h4: begin
                     wide = {1'b0, vx} + {1'b0, vy};
                     shadow_v[x] = wide[7:0];
                     shadow_v[15] = {7'd0, wide[8]};
                  end
                  4'h5: begin
                     shadow_v[x] = vx - vy;
                     shadow_v[15] = {7'd0, vx > vy};
                  end
                  4'h6: begin
                     shadow_v[x] = vx >> 1;
                     shadow_v[15] = {7'd0, vx[0]};
                  end
                  4'h7: begin
                     shadow_v[x] = vy - vx;
                     shadow_v[15] = {7'd0, vy > vx};
                  end
                  4'hE: begin
                     shadow_v[x] = vx << 1;
                     shadow_v[15] = {7'd0, vx[7]};
                  end
                  default: r.bad_opcode = 1'b1;
               endcase
            end
            4'h9: begin
               if (n != 0) r.bad_opcode = 1'b1;
               else if (vx != vy) shadow_pc = shadow_pc + 12'd2;
            end
            4'hA: shadow_index = {4'd0, nnn};
            4'hB: shadow_pc = nnn + {4'd0, shadow_v[0]};
            4'hC: shadow_v[x] = it.random_byte & kk;
            4'hD: r.bad_opcode = 1'b1;
            4'hE: begin
               if (kk == 8'h9E) begin
                  if (it.keys[vx[3:0]]) shadow_pc = shadow_pc + 12'd2;
               end else if (kk == 8'hA1) begin
                  if (!it.keys[vx[3:0]]) shadow_pc = shadow_pc + 12'd2;
               end else r.bad_opcode = 1'b1;
            end
            default: begin
               case (kk)
                  8'h07: shadow_v[x] = shadow_delay;
                  8'h0A: begin
                     if (it.keys == 16'd0) begin
                        shadow_pc = shadow_pc - 12'd2;
                        r.waiting_key = 1'b1;
                     end else begin
                        for (i = 15; i >= 0; i--)
                           if (it.keys[i]) shadow_v[x] = 8'(i);
                     end
                  end
                  8'h15: shadow_delay = vx;
                  8'h18: shadow_sound = vx;
                  8'h1E: shadow_index = shadow_index + {8'd0, vx};
                  8'h29: shadow_index = {4'd0, shadow_font} + 16'(5 * vx[3:0]);
                  8'h33: begin
                     shadow_mem[12'(shadow_index)]     = 8'(vx / 100);
                     shadow_mem[12'(shadow_index + 1)] = 8'((vx / 10) % 10);
                     shadow_mem[12'(shadow_index + 2)] = 8'(vx % 10);
                  end
                  8'h55: for (i = 0; i <= x; i++)
                     shadow_mem[12'(shadow_index + i)] = shadow_v[i];
                  8'h65: for (i = 0; i <= x; i++)
                     shadow_v[i] = shadow_mem[12'(shadow_index + i)];
                  default: r.bad_opcode = 1'b1;
               endcase
            end
         endcase
      end
      r.next_pc = shadow_pc;
      r.index_value = shadow_index;
      r.sound_value = shadow_sound;
      return r;
   endfunction

   // reject items that would read unwritten memory or stack
   function automatic bit item_is_safe(chip8_pkg::req_type it);
      logic [3:0] x;
      int         i, cnt;
      x = it.opcode[11:8];
      if (it.kind == chip8_pkg::KIND_READ) return mem_known[it.mem_address];
      if (it.kind != chip8_pkg::KIND_EXEC) return 1'b1;
      if (it.opcode == 16'h00EE) return stack_depth_known > 0;
      if (it.opcode[15:12] == 4'hF && it.opcode[7:0] == 8'h65) begin
         cnt = x;
         for (i = 0; i <= cnt; i++)
            if (!mem_known[12'(shadow_index + i)]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void note_item(chip8_pkg::req_type it);
      int i, cnt;
      cnt = 0;
      if (it.kind == chip8_pkg::KIND_WRITE) mem_known[it.mem_address] = 1'b1;
      if (it.kind != chip8_pkg::KIND_EXEC) return;
      if (it.opcode == 16'h00EE) stack_depth_known--;
      if (it.opcode[15:12] == 4'h2 && stack_depth_known < 16) stack_depth_known++;
      if (it.opcode[15:12] == 4'hF && it.opcode[7:0] == 8'h33) cnt = 3;
      if (it.opcode[15:12] == 4'hF && it.opcode[7:0] == 8'h55) cnt = it.opcode[11:8] + 1;
      for (i = 0; i < cnt; i++) mem_known[12'(shadow_index + i)] = 1'b1;
   endfunction

   // drive one transfer and record its prediction
   task automatic send_item(chip8_pkg::req_type it);
      if (!item_is_safe(it)) return;
      while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      note_item(it);
      start <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsps.push_back(predict_item(it));
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic chip8_pkg::req_type make_exec(logic [15:0] op, logic [15:0] keys);
      chip8_pkg::req_type it;
      it = '0;
      it.kind = chip8_pkg::KIND_EXEC;
      it.opcode = op;
      it.keys = keys;
      it.random_byte = 8'($urandom);
      it.mem_address = 12'($urandom);
      it.mem_data = 8'($urandom);
      return it;
   endfunction

   task automatic drain_results();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_font_base(logic [11:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_font = value;
      @(posedge clock);
   endtask

   // result checker: strobes cannot be held off, compare every cycle
   always @(posedge clock) begin
      chip8_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         idle_cycles <= 0;
         if (expected_rsps.size() == 0) begin
            $error("result with no expectation waiting");
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.next_pc !== e.next_pc) begin
               $error("next_pc exp %h got %h", e.next_pc, rsp_data.next_pc);
               error_count++;
            end
            if (rsp_data.index_value !== e.index_value) begin
               $error("index_value exp %h got %h", e.index_value, rsp_data.index_value);
               error_count++;
            end
            if (rsp_data.clear_screen !== e.clear_screen) begin
               $error("clear_screen exp %b got %b", e.clear_screen, rsp_data.clear_screen);
               error_count++;
            end
            if (rsp_data.waiting_key !== e.waiting_key) begin
               $error("waiting_key exp %b got %b", e.waiting_key, rsp_data.waiting_key);
               error_count++;
            end
            if (rsp_data.bad_opcode !== e.bad_opcode) begin
               $error("bad_opcode exp %b got %b", e.bad_opcode, rsp_data.bad_opcode);
               error_count++;
            end
            if (rsp_data.read_data !== e.read_data) begin
               $error("read_data exp %h got %h", e.read_data, rsp_data.read_data);
               error_count++;
            end
            if (rsp_data.sound_value !== e.sound_value) begin
               $error("sound_value exp %h got %h", e.sound_value, rsp_data.sound_value);
               error_count++;
            end
         end
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on cycles with no result
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // extremes of every opcode family and the named special cases
   task automatic test_directed();
      chip8_pkg::req_type it;
      send_item(make_exec(16'h00E0, 16'h0000));         // clear screen strobe
      send_item(make_exec(16'h60FF, 16'h0000));         // v0 = ff
      send_item(make_exec(16'h6F01, 16'h0000));
      send_item(make_exec(16'h8F04, 16'h0000));         // add with x = f, flag wins
      send_item(make_exec(16'h6101, 16'h0000));
      send_item(make_exec(16'h8015, 16'h0000));         // sub flag vx > vy
      send_item(make_exec(16'h8017, 16'h0000));         // subn into vx
      send_item(make_exec(16'h800E, 16'h0000));         // shift left flag
      send_item(make_exec(16'h8106, 16'h0000));         // shift right flag
      send_item(make_exec(16'h2FFE, 16'h0000));         // call near top
      send_item(make_exec(16'h00EE, 16'h0000));         // return
      send_item(make_exec(16'h3000, 16'h0000));         // skips on byte
      send_item(make_exec(16'h4000, 16'h0000));
      send_item(make_exec(16'h5010, 16'h0000));
      send_item(make_exec(16'h9010, 16'h0000));
      send_item(make_exec(16'hF00A, 16'h0000));         // key wait, none pressed
      send_item(make_exec(16'hF30A, 16'h8000));         // key wait, only top key
      send_item(make_exec(16'hE09E, 16'hFFFF));
      send_item(make_exec(16'hE0A1, 16'h0000));
      send_item(make_exec(16'hAFFF, 16'h0000));         // index at top, wraps on store
      send_item(make_exec(16'hFF55, 16'h0000));
      send_item(make_exec(16'hFF65, 16'h0000));
      send_item(make_exec(16'hB0FF, 16'h0000));         // jump plus v0
      send_item(make_exec(16'hD123, 16'h0000));         // draw is reported as a bad opcode
      it = make_exec(16'h0000, 16'h0000);
      it.kind = chip8_pkg::KIND_NOP;                    // unused kind
      send_item(it);
   endtask

   // random item mix, mostly valid opcodes with random content
   task automatic test_random(int count);
      chip8_pkg::req_type it;
      logic [15:0] op;
      int          sel;
      repeat (count) begin
         it = make_exec(16'($urandom), 16'($urandom));
         sel = $urandom_range(99);
         op = it.opcode;
         if (sel < 10) begin
            it.kind = chip8_pkg::KIND_WRITE;
         end else if (sel < 18) begin
            it.kind = chip8_pkg::KIND_READ;
         end else if (sel < 20) begin
            it.kind = chip8_pkg::KIND_NOP;
         end else if (sel < 30) begin
            op[15:12] = 4'hF;
            case ($urandom_range(9))
               0: op[7:0] = 8'h07;
               1: op[7:0] = 8'h0A;
               2: op[7:0] = 8'h15;
               3: op[7:0] = 8'h18;
               4: op[7:0] = 8'h1E;
               5: op[7:0] = 8'h29;
               6: op[7:0] = 8'h33;
               7: op[7:0] = 8'h55;
               8: op[7:0] = 8'h65;
               default: ;
            endcase
            if (op[7:0] == 8'h0A && $urandom_range(1)) it.keys = 16'd0;
            it.opcode = op;
         end else if (sel < 40) begin
            op[15:12] = 4'h8;
            op[3:0] = $urandom_range(1) ? 4'hE : 4'($urandom_range(7));
            it.opcode = op;
         end else if (sel < 46) begin
            it.opcode = $urandom_range(1) ? 16'h00EE : 16'h00E0;
         end else if (sel < 52) begin
            op[15:12] = $urandom_range(1) ? 4'h5 : 4'h9;
            if ($urandom_range(3) != 0) op[3:0] = 4'h0;
            it.opcode = op;
         end else if (sel < 58) begin
            op[15:12] = 4'hE;
            op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
            it.opcode = op;
         end
         send_item(it);
      end
   endtask

   initial begin
      error_count = 0;
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      send_gap_pct = 25;
      foreach (shadow_v[i]) shadow_v[i] = '0;
      foreach (shadow_stack[i]) shadow_stack[i] = '0;
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      foreach (mem_known[i]) mem_known[i] = 1'b0;
      stack_depth_known = 0;
      shadow_pc = chip8_pkg::PC_RESET;
      shadow_index = '0;
      shadow_sp = '0;
      shadow_delay = '0;
      shadow_sound = '0;
      shadow_font = chip8_pkg::FONT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      write_font_base(12'hFFF);
      send_item(make_exec(16'hF029, 16'h0000));        // font address beyond the 12-bit memory range
      test_random(230);
      // pause until all results are home, then the other idling phase
      drain_results();
      send_gap_pct = 50;
      write_font_base(12'h000);
      test_random(230);
      send_gap_pct = 0;
      write_font_base(12'($urandom));
      test_random(230);

      drain_results();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
